@@ rtl/swrl_pkg.sv @@
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared widths, register map, divider request/response types and reset
// values for the sliding-window rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;

  // field widths
  localparam int TS_W   = 48;  // microsecond timestamps
  localparam int BKT_W  = 32;  // millisecond count and bucket number
  localparam int LEN_W  = 16;  // bucket length in ms
  localparam int CNT_W  = 7;   // bucket count register
  localparam int TOT_W  = 32;  // per-bucket and window totals
  localparam int WIN_W  = 22;  // window length output
  localparam int DATA_W = 64;  // APB data
  localparam int ADDR_W = 5;   // APB byte address, 8-byte register stride

  // divider: radix-2 steps folded DIV_BITS per clock
  localparam int DIV_BITS       = 4;
  localparam int DIV_CYC_W      = 4;
  localparam int DIV_NARROW_CYC = BKT_W / DIV_BITS;

  localparam logic [LEN_W-1:0] US_PER_MS = 16'd1000;

  // us -> ms: long division by 1000 in 16-bit digits, one digit per cycle.
  // Each digit: n = {rem, digit} < 2^26, q = ((n >> 3) * MS_RECIP) >> MS_SHIFT,
  // which is exact for n >> 3 below 2^23 (MS_RECIP = ceil(2^30 / 125)).
  localparam int MS_CHUNK_W = 16;
  localparam int MS_STEPS   = TS_W / MS_CHUNK_W;
  localparam int MS_REM_W   = 10;
  localparam int MS_NUM_W   = MS_REM_W + MS_CHUNK_W;
  localparam int MS_Y_W     = MS_NUM_W - 3;
  localparam int MS_RECIP_W = 24;
  localparam int MS_SHIFT   = 30;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = 24'd8589935;

  // reset values of the registers
  localparam logic [LEN_W-1:0] RST_BUCKET_MS     = 16'd100;
  localparam logic [CNT_W-1:0] RST_BUCKET_COUNT  = 7'd10;
  localparam logic [TOT_W-1:0] RST_REQUEST_LIMIT = 32'd1000;
  localparam logic [TS_W-1:0]  RST_START_TIME    = 48'd0;

  typedef enum logic [1:0] {
    REG_BUCKET_MS,
    REG_BUCKET_COUNT,
    REG_REQUEST_LIMIT,
    REG_START_TIME
  } reg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [TS_W-1:0]      dividend;
    logic [LEN_W-1:0]     divisor;
    logic [DIV_CYC_W-1:0] cycles;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] quot;
    logic [LEN_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/sliding_window_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Flow: accept, origin subtract, 3 us->ms digit steps, two divider passes (bucket
//   number, then ring index), read, update, output; a bucket change first clears
//   the passed slots, at most the effective bucket count.
// Timestamp before the origin: restart result goes from the subtract state to the output.
// Throughput: one item in flight; the next is taken the cycle after the result
//   is loaded. Reset: synchronous; valid bits clear.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swrl_pkg::TS_W-1:0]     now_us,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          full_res,
  output logic                          restarted,
  output logic [swrl_pkg::WIN_W-1:0]    window_ms,
  output logic [swrl_pkg::TOT_W-1:0]    request_count,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swrl_pkg::ADDR_W-1:0]   paddr,
  input  logic [swrl_pkg::DATA_W-1:0]   pwdata,
  output logic [swrl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import swrl_pkg::*;

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SUB, S_MS, S_DIV_BKT, S_DIV_IDX, S_CLR, S_RD, S_UPD, S_OUT
  } state_t;

  // configuration registers
  logic [LEN_W-1:0] bucket_ms;
  logic [CNT_W-1:0] bucket_count;
  logic [TOT_W-1:0] request_limit;
  logic [TS_W-1:0]  start_time_us;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // sequencer state
  state_t           state;
  logic [TS_W-1:0]  now_r;
  logic [TS_W-1:0]  origin;
  logic [TOT_W-1:0] window_total;
  logic [BKT_W-1:0] last_bucket;
  logic [BKT_W-1:0] bucket_r;
  logic [AW-1:0]    cur;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    pend_idx;
  logic             pend;
  logic [CNT_W-1:0] clr_left;
  logic             res_full;
  logic             res_restart;
  logic [MAX_BUCKETS-1:0] valid;
  logic [MS_REM_W-1:0]    ms_rem;
  logic [MS_CHUNK_W-1:0]  ms_hi;
  logic [1:0]             ms_step;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // datapath
  logic [LEN_W-1:0] eff_len;
  logic [CNT_W-1:0] eff_cnt;
  logic [TS_W:0]    diff;
  logic [BKT_W-1:0] bkt_delta;
  logic [CNT_W-1:0] span;
  logic [AW-1:0]    rd_idx_dec;
  logic             limit_hit;
  logic [TOT_W-1:0] pend_val;
  logic [TOT_W-1:0] slot_val;
  logic [WIN_W:0]   win_prod;
  logic [MS_CHUNK_W-1:0]        ms_chunk;
  logic [MS_NUM_W-1:0]          ms_num;
  logic [MS_Y_W+MS_RECIP_W-1:0] ms_prod;
  logic [MS_CHUNK_W-1:0]        ms_q;
  logic [MS_REM_W-1:0]          ms_rem_next;

  // ring memory
  logic             ram_we;
  logic [TOT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [TOT_W-1:0] ram_rdata;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_ms     <= RST_BUCKET_MS;
      bucket_count  <= RST_BUCKET_COUNT;
      request_limit <= RST_REQUEST_LIMIT;
      start_time_us <= RST_START_TIME;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BUCKET_MS:     bucket_ms     <= pwdata[LEN_W-1:0];
        REG_BUCKET_COUNT:  bucket_count  <= pwdata[CNT_W-1:0];
        REG_REQUEST_LIMIT: request_limit <= pwdata[TOT_W-1:0];
        REG_START_TIME:    start_time_us <= pwdata[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BUCKET_MS:     prdata = DATA_W'(bucket_ms);
      REG_BUCKET_COUNT:  prdata = DATA_W'(bucket_count);
      REG_REQUEST_LIMIT: prdata = DATA_W'(request_limit);
      REG_START_TIME:    prdata = DATA_W'(start_time_us);
      default:           prdata = '0;
    endcase
  end

  // ---------------- effective settings ----------------
  assign eff_len = (bucket_ms == '0) ? LEN_W'(1) : bucket_ms;

  always_comb begin
    if (bucket_count == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
      eff_cnt = CNT_W'(MAX_BUCKETS);
    end else begin
      eff_cnt = bucket_count;
    end
  end

  assign win_prod = (WIN_W + 1)'(eff_len) * (WIN_W + 1)'(eff_cnt);

  // ---------------- datapath ----------------
  assign diff      = {1'b0, now_r} - {1'b0, origin};
  assign bkt_delta = bucket_r - last_bucket;
  assign span      = (bkt_delta > BKT_W'(eff_cnt)) ? eff_cnt : bkt_delta[CNT_W-1:0];
  // ring walks backwards, wrapping at the effective count
  assign rd_idx_dec = (rd_idx == '0) ? AW'(eff_cnt - CNT_W'(1)) : rd_idx - 1'b1;
  assign limit_hit  = window_total >= request_limit;
  // a slot never written since the last clear reads as zero
  assign pend_val   = valid[pend_idx] ? ram_rdata : '0;
  assign slot_val   = valid[cur] ? ram_rdata : '0;

  // us -> ms: one 16-bit digit of the elapsed time per step, top digit first;
  // divide by 8 with a shift, then by 125 with a reciprocal multiply
  always_comb begin
    case (ms_step)
      2'd0:    ms_chunk = diff[TS_W-1 -: MS_CHUNK_W];
      2'd1:    ms_chunk = diff[TS_W-1-MS_CHUNK_W -: MS_CHUNK_W];
      default: ms_chunk = diff[MS_CHUNK_W-1:0];
    endcase
  end

  assign ms_num      = {ms_rem, ms_chunk};
  assign ms_prod     = (MS_Y_W + MS_RECIP_W)'(ms_num[MS_NUM_W-1:3]) *
                       (MS_Y_W + MS_RECIP_W)'(MS_RECIP);
  assign ms_q        = ms_prod[MS_SHIFT +: MS_CHUNK_W];
  assign ms_rem_next = MS_REM_W'(ms_num - MS_NUM_W'(ms_q) * MS_NUM_W'(US_PER_MS));

  // memory port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur;
    if (state == S_CLR && clr_left != '0) begin
      ram_re    = 1'b1;
      ram_raddr = rd_idx;
    end else if (state == S_RD) begin
      ram_re = 1'b1;
    end
    ram_we    = (state == S_UPD) && !limit_hit;
    ram_wdata = (slot_val == '1) ? slot_val : slot_val + 1'b1;
  end

  assign in_stall = (state != S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      origin       <= RST_START_TIME;
      window_total <= '0;
      last_bucket  <= '0;
      valid        <= '0;
      pend         <= 1'b0;
      div_req      <= '0;
      out_valid    <= 1'b0;
    end else begin
      // divider start is a one-cycle pulse
      if (div_req.start) begin
        div_req.start <= 1'b0;
      end
      // result taken and no new one loaded
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      // a restart takes the origin from the item; a start time write moves it too
      if (state == S_SUB && diff[TS_W]) begin
        origin <= now_r;
      end else if (cfg_wr && cfg_idx == REG_START_TIME) begin
        origin <= pwdata[TS_W-1:0];
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            now_r <= now_us;
            state <= S_SUB;
          end
        end

        S_SUB: begin
          res_full <= 1'b0;
          if (diff[TS_W]) begin
            // timestamp before origin: restart everything
            valid        <= '0;
            window_total <= '0;
            last_bucket  <= '0;
            res_restart  <= 1'b1;
            state        <= S_OUT;
          end else begin
            ms_rem      <= '0;
            ms_step     <= '0;
            res_restart <= 1'b0;
            state       <= S_MS;
          end
        end

        S_MS: begin
          ms_rem  <= ms_rem_next;
          ms_hi   <= ms_q;
          ms_step <= ms_step + 1'b1;
          if (ms_step == 2'(MS_STEPS - 1)) begin
            // low 32 bits of the ms count go on to the bucket divide
            div_req <= '{1'b1, {ms_hi, ms_q, {(TS_W - BKT_W){1'b0}}}, eff_len,
                         DIV_CYC_W'(DIV_NARROW_CYC)};
            state   <= S_DIV_BKT;
          end
        end

        S_DIV_BKT: begin
          if (div_rsp.done) begin
            bucket_r <= div_rsp.quot;
            div_req  <= '{1'b1, {div_rsp.quot, {(TS_W - BKT_W){1'b0}}},
                          LEN_W'(eff_cnt), DIV_CYC_W'(DIV_NARROW_CYC)};
            state    <= S_DIV_IDX;
          end
        end

        S_DIV_IDX: begin
          if (div_rsp.done) begin
            cur      <= AW'(div_rsp.rem);
            rd_idx   <= AW'(div_rsp.rem);
            clr_left <= span;
            pend     <= 1'b0;
            if (bucket_r != last_bucket) begin
              last_bucket <= bucket_r;
              state       <= S_CLR;
            end else begin
              state <= S_RD;
            end
          end
        end

        S_CLR: begin
          // read one slot per cycle, retire the previous read
          if (clr_left != '0) begin
            pend     <= 1'b1;
            pend_idx <= rd_idx;
            rd_idx   <= rd_idx_dec;
            clr_left <= clr_left - 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            window_total    <= (window_total >= pend_val) ? window_total - pend_val : '0;
            valid[pend_idx] <= 1'b0;
          end
          if (clr_left == '0 && !pend) begin
            state <= S_RD;
          end
        end

        S_RD: begin
          state <= S_UPD;
        end

        S_UPD: begin
          if (limit_hit) begin
            res_full <= 1'b1;
          end else begin
            valid[cur] <= 1'b1;
            if (window_total != '1) begin
              window_total <= window_total + 1'b1;
            end
          end
          state <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            full_res      <= res_full;
            restarted     <= res_restart;
            window_ms     <= win_prod[WIN_W-1:0];
            request_count <= window_total;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- submodules ----------------
  swrl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  swrl_ram #(
    .WIDTH (TOT_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ rtl/swrl_ram.sv @@
// ----------------------------------------------------------------------------
// swrl_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module swrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/swrl_div.sv @@
// ----------------------------------------------------------------------------
// swrl_div
// Iterative restoring divider, DIV_BITS quotient bits per clock. The dividend
// is left aligned in 48 bits; a 32-bit dividend is loaded shifted up by 16
// and run for fewer cycles. Quotient low 32 bits and 16-bit remainder out.
// ----------------------------------------------------------------------------
module swrl_div (
  input  logic                clk,
  input  logic                rst,
  input  swrl_pkg::div_req_t  req,
  output swrl_pkg::div_rsp_t  rsp
);
  import swrl_pkg::*;

  localparam int REM_W = LEN_W + 1;

  logic [REM_W-1:0]     rem;
  logic [TS_W-1:0]      dvd;
  logic [LEN_W-1:0]     divisor;
  logic [DIV_CYC_W-1:0] cyc_left;
  logic                 busy;
  logic                 done;
  logic [REM_W-1:0]     rem_next;
  logic [TS_W-1:0]      dvd_next;

  // DIV_BITS shift / compare / subtract steps
  always_comb begin
    logic [REM_W-1:0] r;
    logic [TS_W-1:0]  d;
    r = rem;
    d = dvd;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[REM_W-2:0], d[TS_W-1]};
      d = {d[TS_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        d[0] = 1'b1;
      end
    end
    rem_next = r;
    dvd_next = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // one-cycle pulse after the last step
      done <= busy && !req.start && (cyc_left == DIV_CYC_W'(1));
      if (req.start) begin
        dvd      <= req.dividend;
        rem      <= '0;
        divisor  <= req.divisor;
        cyc_left <= req.cycles;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= rem_next;
        dvd      <= dvd_next;
        cyc_left <= cyc_left - 1'b1;
        if (cyc_left == DIV_CYC_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd[BKT_W-1:0];
  assign rsp.rem  = rem[LEN_W-1:0];

endmodule

@@ rtl/swrl_chk.sv @@
// ----------------------------------------------------------------------------
// swrl_chk
// Port-level checks for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module swrl_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       full_res,
  input logic                       restarted,
  input logic [swrl_pkg::TOT_W-1:0] request_count
);
  import swrl_pkg::*;

  // one item in flight: the cycle after an accept the input is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in flight");

  // a restart is never a refusal and leaves an empty window
  a_restart_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && restarted) |-> (!full_res && request_count == '0))
    else $error("restart result carries a count or refusal");

  // a counted request leaves at least one item in the window
  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !restarted && !full_res) |-> (request_count != '0))
    else $error("counted request with empty window");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(request_count) && $stable(full_res) && $stable(restarted)))
    else $error("stalled result changed");

endmodule

bind sliding_window_rate_limiter swrl_chk u_chk (.*);

@@ dv/tb_sliding_window_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_limiter
// Self-checking bench for the sliding-window rate limiter. It drives request
// items with microsecond timestamps and programs the four registers over APB.
// An in-bench model of the bucket ring works out each verdict, and results
// are checked in order, field by field. A short directed table covers resets,
// refusals, restarts and register extremes. Six randomized segments follow,
// each with fresh register settings and varied idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  import swrl_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [TS_W-1:0] STAMP_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic             refused;
    logic             restart;
    logic [WIN_W-1:0] win_len;
    logic [TOT_W-1:0] total;
  } verdict_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    target;
    logic [63:0] value;
    logic        checked;
    verdict_t    want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [TS_W-1:0]    now_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               full_res;
  logic               restarted;
  logic [WIN_W-1:0]   window_ms;
  logic [TOT_W-1:0]   request_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  sliding_window_rate_limiter #(.MAX_BUCKETS(SLOTS)) DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // register shadow
  logic [LEN_W-1:0] len_reg;
  logic [CNT_W-1:0] count_reg;
  logic [TOT_W-1:0] limit_reg;

  // window state shadow
  logic [TS_W-1:0]  origin_q;
  logic [TOT_W-1:0] slot_hits [SLOTS];
  logic [TOT_W-1:0] window_sum;
  logic [BKT_W-1:0] last_bkt;

  verdict_t pending_verdicts [$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  function automatic logic [31:0] len_eff();
    return (len_reg == 0) ? 32'd1 : 32'(len_reg);
  endfunction

  function automatic logic [31:0] count_eff();
    if (count_reg == 0) return 32'd1;
    if (count_reg > SLOTS) return 32'(SLOTS);
    return 32'(count_reg);
  endfunction

  function automatic void clear_window();
    foreach (slot_hits[k]) slot_hits[k] = '0;
    window_sum = '0;
    last_bkt = '0;
  endfunction

  // verdict for one request; updates the window state
  function automatic verdict_t judge_request(input logic [TS_W-1:0] ts);
    logic [31:0] len;
    logic [31:0] cnt;
    logic [TS_W-1:0] elapsed;
    logic [31:0] bkt;
    logic [31:0] cur;
    logic [31:0] span;
    logic [31:0] idx;
    int i;
    verdict_t v;
    len = len_eff();
    cnt = count_eff();
    v = '0;
    if (ts < origin_q) begin
      // time went backwards: start over from this stamp
      origin_q = ts;
      clear_window();
      v.restart = 1'b1;
    end else begin
      elapsed = (ts - origin_q) / 48'd1000;
      bkt = elapsed[31:0] / len;
      cur = bkt % cnt;
      if (bkt != last_bkt) begin
        // retire the slots passed since the last bucket
        span = bkt - last_bkt;
        if (span > cnt) span = cnt;
        last_bkt = bkt;
        for (i = 0; i < span; i++) begin
          idx = (cur + cnt - i) % cnt;
          window_sum = (window_sum >= slot_hits[idx]) ? window_sum - slot_hits[idx] : '0;
          slot_hits[idx] = '0;
        end
      end
      if (window_sum >= limit_reg) begin
        v.refused = 1'b1;
      end else begin
        if (slot_hits[cur] != '1) slot_hits[cur]++;
        if (window_sum != '1) window_sum++;
      end
    end
    v.win_len = WIN_W'(len * cnt);
    v.total = window_sum;
    return v;
  endfunction

  function automatic logic [TS_W-1:0] rand_stamp();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
  endfunction

  // next request time: mostly small forward steps, some long jumps,
  // some stamps before the origin and some anywhere
  function automatic logic [TS_W-1:0] next_stamp(input logic [TS_W-1:0] prev);
    logic [63:0] unit;
    logic [63:0] step;
    int pick;
    unit = 64'(len_eff()) * 64'd1000;
    pick = $urandom_range(0, 99);
    step = '0;
    if (pick < 50) step = 64'($urandom_range(0, 32'(unit / 4)));
    else if (pick < 80) step = 64'($urandom_range(0, 32'(unit * 2)));
    else if (pick < 88) step = unit * $urandom_range(count_eff(), 2 * count_eff());
    else if (pick < 94) return (origin_q != 0) ? TS_W'(rand_stamp() % origin_q) : rand_stamp();
    else return rand_stamp();
    return TS_W'(prev + step);
  endfunction

  function automatic plan_row_t cfg_row(input reg_idx_t target, input logic [63:0] value);
    return '{ROW_CFG, target, value, 1'b0, '0};
  endfunction

  function automatic plan_row_t req_row(input logic [TS_W-1:0] ts);
    return '{ROW_REQ, REG_BUCKET_MS, 64'(ts), 1'b0, '0};
  endfunction

  function automatic plan_row_t known_row(input logic [TS_W-1:0] ts, input logic refused,
                                          input logic restart, input logic [WIN_W-1:0] win,
                                          input logic [TOT_W-1:0] total);
    return '{ROW_REQ, REG_BUCKET_MS, 64'(ts), 1'b1, '{refused, restart, win, total}};
  endfunction

  // APB write: setup, then access until pready
  task automatic write_reg(input reg_idx_t target, input logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {target, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (target)
      REG_BUCKET_MS:     len_reg = value[LEN_W-1:0];
      REG_BUCKET_COUNT:  count_reg = value[CNT_W-1:0];
      REG_REQUEST_LIMIT: limit_reg = value[TOT_W-1:0];
      REG_START_TIME:    origin_q = value[TS_W-1:0];
      default: ;
    endcase
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offer one item, hold it until taken, then record its verdict
  task automatic send_request(input logic [TS_W-1:0] ts, input logic checked,
                              input verdict_t want);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    now_us <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = judge_request(ts);
    pending_verdicts.push_back(checked ? want : v);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall, in-order check
  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result item with no request pending");
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("full_res", 64'(want.refused), 64'(full_res));
        compare_field("restarted", 64'(want.restart), 64'(restarted));
        compare_field("window_ms", 64'(want.win_len), 64'(window_ms));
        compare_field("request_count", 64'(want.total), 64'(request_count));
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // stimulus
  initial begin
    plan_row_t plan [$];
    logic [TS_W-1:0] stamp;
    logic [63:0] value;
    len_reg = RST_BUCKET_MS;
    count_reg = RST_BUCKET_COUNT;
    limit_reg = RST_REQUEST_LIMIT;
    origin_q = RST_START_TIME;
    clear_window();

    // directed: reset defaults, bucket change, restart, limit and length extremes
    plan.push_back(known_row(48'd0, 1'b0, 1'b0, 22'd1000, 32'd1));
    plan.push_back(known_row(48'd99_999, 1'b0, 1'b0, 22'd1000, 32'd2));
    plan.push_back(known_row(48'd100_000, 1'b0, 1'b0, 22'd1000, 32'd3));
    plan.push_back(req_row(48'd1_100_000));
    plan.push_back(cfg_row(REG_START_TIME, 64'd5000));
    plan.push_back(known_row(48'd4999, 1'b0, 1'b1, 22'd1000, 32'd0));
    plan.push_back(known_row(48'd4999, 1'b0, 1'b0, 22'd1000, 32'd1));
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 64'd0));
    plan.push_back(known_row(48'd5000, 1'b1, 1'b0, 22'd1000, 32'd1));
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 64'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_BUCKET_MS, 64'd0));
    plan.push_back(cfg_row(REG_BUCKET_COUNT, 64'd0));
    plan.push_back(known_row(48'd5999, 1'b0, 1'b0, 22'd1, 32'd1));
    plan.push_back(cfg_row(REG_BUCKET_COUNT, 64'd127));
    plan.push_back(cfg_row(REG_BUCKET_MS, 64'd65535));
    plan.push_back(req_row(STAMP_MAX));
    plan.push_back(known_row(48'd0, 1'b0, 1'b1, 22'd4194240, 32'd0));
    plan.push_back(cfg_row(REG_START_TIME, 64'(STAMP_MAX)));
    plan.push_back(known_row(STAMP_MAX, 1'b0, 1'b0, 22'd4194240, 32'd1));
    plan.push_back(known_row(STAMP_MAX - 1, 1'b0, 1'b1, 22'd4194240, 32'd0));
    plan.push_back(cfg_row(REG_BUCKET_MS, 64'd1));
    plan.push_back(cfg_row(REG_BUCKET_COUNT, 64'd1));
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 64'd2));
    plan.push_back(cfg_row(REG_START_TIME, 64'd0));
    plan.push_back(known_row(48'd0, 1'b0, 1'b0, 22'd1, 32'd1));
    plan.push_back(known_row(48'd500, 1'b0, 1'b0, 22'd1, 32'd2));
    plan.push_back(known_row(48'd999, 1'b1, 1'b0, 22'd1, 32'd2));
    plan.push_back(known_row(48'd1000, 1'b0, 1'b0, 22'd1, 32'd1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 50;
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        settle();
        write_reg(plan[k].target, plan[k].value);
      end else begin
        send_request(plan[k].value[TS_W-1:0], plan[k].checked, plan[k].want);
      end
    end

    // random segments, each with its own register settings
    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 50 : 0;
      recv_idle_pct = (seg < 2) ? 50 : (seg < 4) ? 31 : 0;
      settle();
      case ($urandom_range(0, 7))
        0: value = 64'd0;
        1: value = 64'd65535;
        2: value = 64'd1;
        default: value = 64'($urandom_range(1, 20));
      endcase
      write_reg(REG_BUCKET_MS, value);
      case ($urandom_range(0, 7))
        0: value = 64'd0;
        1: value = 64'd1;
        2: value = 64'(SLOTS);
        3: value = 64'd127;
        4: value = 64'($urandom_range(SLOTS + 1, 127));
        default: value = 64'($urandom_range(2, 12));
      endcase
      write_reg(REG_BUCKET_COUNT, value);
      case ($urandom_range(0, 7))
        0: value = 64'd0;
        1: value = 64'hFFFF_FFFF;
        default: value = 64'($urandom_range(1, 24));
      endcase
      write_reg(REG_REQUEST_LIMIT, value);
      case ($urandom_range(0, 7))
        0: value = 64'd0;
        1: value = 64'(STAMP_MAX);
        default: value = 64'(TS_W'($urandom) << $urandom_range(0, 16));
      endcase
      write_reg(REG_START_TIME, value);
      stamp = origin_q;
      for (int n = 0; n < 100; n++) begin
        stamp = next_stamp(stamp);
        send_request(stamp, 1'b0, '0);
      end
    end

    // drain, then watch for stray results
    in_valid <= 1'b0;
    while (pending_verdicts.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("** sliding_window_rate_limiter: PASSED **");
    end else begin
      $display("** sliding_window_rate_limiter: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("** sliding_window_rate_limiter: FAILED **");
    $finish;
  end

endmodule
